[hdl/qrv_pkg.sv]
// ----------------------------------------------------------------------------
// qrv_pkg
// Shared request codes, status codes and cell control type for the queue
// with remove by value.
// ----------------------------------------------------------------------------
package qrv_pkg;

    localparam int VALUE_W  = 32;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NOP    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    localparam logic signed [VALUE_W-1:0] EMPTY_RESULT = -32'sd1;

    typedef struct packed {
        logic push;
        logic pop;
        logic remove;
    } t_cell_ctl;

endpackage

[hdl/qrv_cell.sv]
// ----------------------------------------------------------------------------
// qrv_cell
// One queue slot. Holds a value, compares it to the request value, loads
// it at the tail on push and takes its neighbor's value on pop or remove.
// ----------------------------------------------------------------------------
module qrv_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 5
) (
    input  logic                                  i_clk,
    input  qrv_pkg::t_cell_ctl                    i_ctl,
    input  logic signed [qrv_pkg::VALUE_W-1:0]    i_value,
    input  logic [CW-1:0]                         i_count,
    input  logic                                  i_found,
    input  logic signed [qrv_pkg::VALUE_W-1:0]    i_next_value,
    output logic                                  o_found,
    output logic signed [qrv_pkg::VALUE_W-1:0]    o_value
);

    logic signed [qrv_pkg::VALUE_W-1:0] r_value;
    logic signed [qrv_pkg::VALUE_W-1:0] n_value;
    logic                               in_use;
    logic                               at_tail;
    logic                               match;

    assign in_use  = CW'(INDEX) < i_count;
    assign at_tail = CW'(INDEX) == i_count;
    assign match   = in_use && (r_value == i_value);
    assign o_found = i_found || match;
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.push && at_tail) begin
            n_value = i_value;
        end else if (i_ctl.pop && in_use) begin
            n_value = i_next_value;
        end else if (i_ctl.remove && o_found) begin
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

[hdl/queue_with_remove_by_value.sv]
// ----------------------------------------------------------------------------
// queue_with_remove_by_value
// Bounded ordered queue of signed values built as a row of slots. Push
// appends at the tail, pop returns the head, remove deletes the first match.
//
//   channel   handshake                    payload
//   request   i_in_valid / o_in_ready      i_req_type, i_value
//   result    o_out_valid / i_out_ready    o_result_value, o_status,
//                                          o_entry_count, o_is_empty
//
// One request is taken per cycle while ready; its result appears in the
// output register on the next cycle. Compare and shift happen in all slots
// in the same cycle, and the match flag ripples from head to tail through
// the slots. A new request is taken while the held result is being taken.
// Reset empties the queue and drops any held result; no clearing pass.
// ----------------------------------------------------------------------------
module queue_with_remove_by_value #(
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [qrv_pkg::REQ_W-1:0]             i_req_type,
    input  logic signed [qrv_pkg::VALUE_W-1:0]    i_value,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [qrv_pkg::VALUE_W-1:0]    o_result_value,
    output logic [qrv_pkg::STATUS_W-1:0]          o_status,
    output logic [qrv_pkg::COUNT_W-1:0]           o_entry_count,
    output logic                                  o_is_empty
);

    localparam int CW = $clog2(DEPTH + 1);

    logic                                  accept;
    qrv_pkg::t_cell_ctl                    ctl;
    logic signed [qrv_pkg::VALUE_W-1:0]    cell_value [DEPTH];
    logic                                  found_chain [DEPTH+1];
    logic                                  full;
    logic                                  empty;

    logic [CW-1:0]                         r_count;
    logic [CW-1:0]                         n_count;
    logic                                  r_out_valid;
    logic signed [qrv_pkg::VALUE_W-1:0]    r_result;
    logic signed [qrv_pkg::VALUE_W-1:0]    n_result;
    logic [qrv_pkg::STATUS_W-1:0]          r_status;
    logic [qrv_pkg::STATUS_W-1:0]          n_status;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign full       = r_count == CW'(DEPTH);
    assign empty      = r_count == '0;

    assign ctl.push   = accept && (i_req_type == qrv_pkg::REQ_PUSH) && !full;
    assign ctl.pop    = accept && (i_req_type == qrv_pkg::REQ_POP) && !empty;
    assign ctl.remove = accept && (i_req_type == qrv_pkg::REQ_REMOVE);

    assign found_chain[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [qrv_pkg::VALUE_W-1:0] next_value;
        if (g == DEPTH - 1) begin : g_last
            assign next_value = '0;
        end else begin : g_mid
            assign next_value = cell_value[g+1];
        end
        qrv_cell #(
            .INDEX (g),
            .CW    (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_value      (i_value),
            .i_count      (r_count),
            .i_found      (found_chain[g]),
            .i_next_value (next_value),
            .o_found      (found_chain[g+1]),
            .o_value      (cell_value[g])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_result = '0;
        n_status = qrv_pkg::ST_OK;
        case (i_req_type)
            qrv_pkg::REQ_PUSH: begin
                if (full) begin
                    n_status = qrv_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            qrv_pkg::REQ_POP: begin
                if (empty) begin
                    n_result = qrv_pkg::EMPTY_RESULT;
                    n_status = qrv_pkg::ST_EMPTY;
                end else begin
                    n_result = cell_value[0];
                    n_count  = r_count - CW'(1);
                end
            end
            qrv_pkg::REQ_REMOVE: begin
                if (empty) begin
                    n_status = qrv_pkg::ST_EMPTY;
                end else if (found_chain[DEPTH]) begin
                    n_count = r_count - CW'(1);
                end else begin
                    n_status = qrv_pkg::ST_NOT_FOUND;
                end
            end
            qrv_pkg::REQ_NOP: begin
                n_status = qrv_pkg::ST_OK;
            end
            default: begin
                n_status = qrv_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
            r_status <= n_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_result;
    assign o_status       = r_status;
    assign o_entry_count  = qrv_pkg::COUNT_W'(r_count);
    assign o_is_empty     = r_count == '0;

endmodule
